@@ rtl/cah_pkg.sv @@
// Shared types and constants for the column adaptation / habituation block.
// Holds the item structs, request and register codes, and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cah_pkg;

   localparam int COLUMNS_DEFAULT = 256;

   localparam int REQ_W      = 3;
   localparam int COL_W      = 8;
   localparam int LEVEL_W    = 17;
   localparam int ACTIVE_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Q1.16 one
   localparam logic [LEVEL_W-1:0] Q_ONE = 17'h10000;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ADAPT     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_HABIT     = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TICK      = 3'd2;
   localparam logic [REQ_W-1:0] REQ_CLR_ADAPT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLR_HABIT = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLUMNS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HABIT_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_DECAY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HABIT_DECAY    = 3'd4;

   // Register reset values
   localparam logic [ACTIVE_W-1:0] ACTIVE_COLUMNS_RST = 9'd256;
   localparam logic [LEVEL_W-1:0]  ADAPT_GAIN_RST     = 17'd6554;
   localparam logic [LEVEL_W-1:0]  HABIT_GAIN_RST     = 17'd3277;
   localparam logic [LEVEL_W-1:0]  DECAY_RST          = 17'h10000;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [COL_W-1:0]   column;
      logic [LEVEL_W-1:0] activity;
   } req_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] shaped_activity;
      logic               status;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/column_adaptation_habituation.sv @@
// Column adaptation / habituation top level: level memory, request sequencer, tick walker.
// Depends on cah_pkg for item structs, request and register codes.
// Column requests: the level memory is read on acceptance and written back in the modify
//   state; a new item can be accepted while the result of the last is being registered.
// Tick: walks columns 0..n-1 through a 3-stage read / multiply / write pipeline,
//   n = min(active_columns, COLUMNS); the next item is taken once the pipeline has drained.
// Reset: synchronous; a clearing pass then zeroes every entry of the level memory,
//   busy stays high meanwhile. Results cannot be stalled: rsp_valid marks one cycle.
`timescale 1ns / 1ps
`default_nettype none

module column_adaptation_habituation #(
   parameter int COLUMNS = cah_pkg::COLUMNS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire cah_pkg::req_item_type               req_item,
   // result channel
   output logic                                     rsp_valid,
   output cah_pkg::rsp_item_type                    rsp_item,
   // register write port
   input  wire logic                                csr_we,
   input  wire logic [cah_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cah_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int LW = cah_pkg::LEVEL_W;
   localparam int PW = 2 * LW;            // product width
   localparam int WW = 2 * LW;            // memory word: {habit, adapt}
   localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CNTW = ($clog2(COLUMNS + 1) > cah_pkg::ACTIVE_W) ?
                         $clog2(COLUMNS + 1) : cah_pkg::ACTIVE_W;
   localparam logic [CNTW-1:0] COLUMNS_N = CNTW'(COLUMNS);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(COLUMNS - 1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;
   localparam logic [2:0] ST_TICK  = 3'd4;

   // Scale a Q1.16 product back to Q1.16 and clamp it to one.
   function automatic logic [LW-1:0] clamp_prod(input logic [PW-1:0] p);
      logic [LW:0] scaled;
      scaled = p[PW-1:16];
      return (scaled > {1'b0, cah_pkg::Q_ONE}) ? cah_pkg::Q_ONE : scaled[LW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [2:0]                     state_ff, state_in;
   logic [AW-1:0]                  clr_cnt_ff, clr_cnt_in;

   logic [cah_pkg::ACTIVE_W-1:0]   active_ff;
   logic [LW-1:0]                  adapt_gain_ff, habit_gain_ff;
   logic [LW-1:0]                  adapt_decay_ff, habit_decay_ff;

   // latched request
   logic [cah_pkg::REQ_W-1:0]      type_ff, type_in;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic                           col_ok_ff, col_ok_in;
   logic [LW-1:0]                  act_ff, act_in;
   logic [PW-1:0]                  prod_ff, prod_in;

   // update results
   logic [LW-1:0]                  lvl_ff, lvl_in;
   logic                           status_ff, status_in;
   logic                           op_ok_ff, op_ok_in;

   // tick walker
   logic [CNTW-1:0]                issue_cnt_ff, issue_cnt_in;
   logic                           s1_vld_ff, s1_vld_in;
   logic [AW-1:0]                  s1_addr_ff, s1_addr_in;
   logic                           s2_vld_ff, s2_vld_in;
   logic [AW-1:0]                  s2_addr_ff, s2_addr_in;
   logic [PW-1:0]                  pa_ff, pa_in;
   logic [PW-1:0]                  ph_ff, ph_in;

   // result
   logic                           rsp_valid_ff, rsp_valid_in;
   cah_pkg::rsp_item_type          rsp_ff, rsp_in;

   // level memory
   logic [WW-1:0]                  mem [COLUMNS];
   logic [WW-1:0]                  rd_data_ff;
   logic [AW-1:0]                  rd_addr;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [WW-1:0]                  wr_data;

   // ------------------------------------------------------------------
   // Combinational helpers
   // ------------------------------------------------------------------
   logic [CNTW-1:0]  active_ext, n_cols, col_ext;
   logic             req_col_ok, accept, issuing;
   logic [AW-1:0]    req_addr, issue_addr;
   logic [LW-1:0]    gain_sel, lvl_old, lvl_new;
   logic [LW+1:0]    lvl_sum;
   logic             act_ok, fatigue_ok;
   logic [PW-1:0]    shaped_prod;

   // Columns in use are capped at the memory depth.
   assign active_ext = CNTW'(active_ff);
   assign n_cols     = (active_ext > COLUMNS_N) ? COLUMNS_N : active_ext;
   assign col_ext    = CNTW'(req_item.column);
   assign req_col_ok = col_ext < n_cols;
   assign req_addr   = col_ext[AW-1:0];

   // Ready during the result cycle too: the memory write of the last item is done by then.
   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_OUT));
   assign accept = start && !busy;

   assign gain_sel = (req_item.req_type == cah_pkg::REQ_HABIT) ? habit_gain_ff : adapt_gain_ff;

   // Fatigue update: level plus scaled gain*activity, clamped to one.
   assign lvl_old    = (type_ff == cah_pkg::REQ_ADAPT) ? rd_data_ff[LW-1:0] : rd_data_ff[WW-1:LW];
   assign lvl_sum    = {2'b00, lvl_old} + {1'b0, prod_ff[PW-1:16]};
   assign lvl_new    = (lvl_sum > {2'b00, cah_pkg::Q_ONE}) ? cah_pkg::Q_ONE : lvl_sum[LW-1:0];
   assign act_ok     = act_ff <= cah_pkg::Q_ONE;
   assign fatigue_ok = col_ok_ff && act_ok;

   // Shaped output: activity times (one minus new level).
   assign shaped_prod = PW'(act_ff) * PW'(cah_pkg::Q_ONE - lvl_ff);

   // Tick walker issues one read a cycle until all columns in use are covered.
   assign issuing    = (state_ff == ST_TICK) && (issue_cnt_ff < n_cols);
   assign issue_addr = issue_cnt_ff[AW-1:0];
   assign rd_addr    = (state_ff == ST_TICK) ? issue_addr : req_addr;

   // ------------------------------------------------------------------
   // Memory write port
   // ------------------------------------------------------------------
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // after reset, zero one entry a cycle
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         ST_MOD: begin
            unique case (type_ff)
               cah_pkg::REQ_ADAPT: begin
                  wr_en   = fatigue_ok;
                  wr_data = {rd_data_ff[WW-1:LW], lvl_new};
               end
               cah_pkg::REQ_HABIT: begin
                  wr_en   = fatigue_ok;
                  wr_data = {lvl_new, rd_data_ff[LW-1:0]};
               end
               cah_pkg::REQ_CLR_ADAPT: begin
                  wr_en   = col_ok_ff;
                  wr_data = {rd_data_ff[WW-1:LW], {LW{1'b0}}};
               end
               cah_pkg::REQ_CLR_HABIT: begin
                  wr_en   = col_ok_ff;
                  wr_data = {{LW{1'b0}}, rd_data_ff[LW-1:0]};
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end
         ST_TICK: begin
            // write back decayed levels from stage 2, after the read data and the products are registered
            wr_en   = s2_vld_ff;
            wr_addr = s2_addr_ff;
            wr_data = {clamp_prod(ph_ff), clamp_prod(pa_ff)};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Sequencer next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      type_in      = type_ff;
      addr_in      = addr_ff;
      col_ok_in    = col_ok_ff;
      act_in       = act_ff;
      prod_in      = prod_ff;
      lvl_in       = lvl_ff;
      status_in    = status_ff;
      op_ok_in     = op_ok_ff;
      issue_cnt_in = issue_cnt_ff;
      s1_vld_in    = 1'b0;
      s1_addr_in   = s1_addr_ff;
      s2_vld_in    = 1'b0;
      s2_addr_in   = s2_addr_ff;
      pa_in        = pa_ff;
      ph_in        = ph_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_OUT: begin
            if (state_ff == ST_OUT) begin
               // present the finished item for one cycle
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.shaped_activity = op_ok_ff ? shaped_prod[32:16] : '0;
            end
            state_in = ST_IDLE;
            if (accept) begin
               // latch the item; the memory read launches on this edge
               type_in      = req_item.req_type;
               addr_in      = req_addr;
               col_ok_in    = req_col_ok;
               act_in       = req_item.activity;
               prod_in      = PW'(gain_sel) * PW'(req_item.activity);
               status_in    = 1'b0;
               op_ok_in     = 1'b0;
               issue_cnt_in = '0;
               state_in     = (req_item.req_type == cah_pkg::REQ_TICK) ? ST_TICK : ST_MOD;
            end
         end
         ST_MOD: begin
            lvl_in   = lvl_new;
            state_in = ST_OUT;
            unique case (type_ff)
               cah_pkg::REQ_ADAPT, cah_pkg::REQ_HABIT: begin
                  status_in = !fatigue_ok;
                  op_ok_in  = fatigue_ok;
               end
               cah_pkg::REQ_CLR_ADAPT, cah_pkg::REQ_CLR_HABIT: begin
                  status_in = !col_ok_ff;
               end
               default: begin
                  status_in = 1'b0;
               end
            endcase
         end
         ST_TICK: begin
            // stage 0: issue read
            if (issuing) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
               s1_vld_in    = 1'b1;
               s1_addr_in   = issue_addr;
            end
            // stage 1: read data back, multiply by the decay factors
            s2_vld_in  = s1_vld_ff;
            s2_addr_in = s1_addr_ff;
            pa_in      = PW'(rd_data_ff[LW-1:0]) * PW'(adapt_decay_ff);
            ph_in      = PW'(rd_data_ff[WW-1:LW]) * PW'(habit_decay_ff);
            // stage 2 writes through the memory port; finish once drained
            if (!issuing && !s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_OUT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Register update
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         s1_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= cah_pkg::ACTIVE_COLUMNS_RST;
         adapt_gain_ff  <= cah_pkg::ADAPT_GAIN_RST;
         habit_gain_ff  <= cah_pkg::HABIT_GAIN_RST;
         adapt_decay_ff <= cah_pkg::DECAY_RST;
         habit_decay_ff <= cah_pkg::DECAY_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cah_pkg::CSR_ACTIVE_COLUMNS: active_ff      <= csr_wdata[cah_pkg::ACTIVE_W-1:0];
               cah_pkg::CSR_ADAPT_GAIN:     adapt_gain_ff  <= csr_wdata;
               cah_pkg::CSR_HABIT_GAIN:     habit_gain_ff  <= csr_wdata;
               cah_pkg::CSR_ADAPT_DECAY:    adapt_decay_ff <= csr_wdata;
               cah_pkg::CSR_HABIT_DECAY:    habit_decay_ff <= csr_wdata;
               default: begin
                  // drop writes to unknown indexes
               end
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      addr_ff      <= addr_in;
      col_ok_ff    <= col_ok_in;
      act_ff       <= act_in;
      prod_ff      <= prod_in;
      lvl_ff       <= lvl_in;
      status_ff    <= status_in;
      op_ok_ff     <= op_ok_in;
      issue_cnt_ff <= issue_cnt_in;
      s1_addr_ff   <= s1_addr_in;
      s2_addr_ff   <= s2_addr_in;
      pa_ff        <= pa_in;
      ph_ff        <= ph_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_OUT))
      else $error("result strobe without a finished item");

   a_busy_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> busy)
      else $error("item could be taken during the clearing pass");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff != ST_IDLE) && (state_ff != ST_OUT)))
      else $error("memory write while idle");

   a_tick_pipe: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> $past(s1_vld_ff))
      else $error("tick write stage without a read");
`endif

endmodule

`default_nettype wire
